FILE: src/vad_pkg.sv
package vad_pkg;

    localparam int SampleWindow   = 25;
    localparam int VarianceWindow = 25;
    localparam int SampleBits     = 10;
    localparam int IdxW           = 5;
    localparam int VarW           = 27;
    localparam int SpreadW        = 52;
    localparam int TimeW          = 32;
    localparam int CfgW           = 52;
    localparam int CfgIdxW        = 2;

    // Numerator and divisor widths for the two modes of the shared serial divider.
    localparam int NumW1 = 40;
    localparam int NumW2 = 72;
    localparam int DivW1 = 10;
    localparam int DivW2 = 10;

    localparam logic [DivW1-1:0] SampleDen   = DivW1'(SampleWindow * (SampleWindow - 1));
    localparam logic [DivW2-1:0] VarianceDen = DivW2'(VarianceWindow * (VarianceWindow - 1));

    localparam logic [VarW-1:0]    VarMax    = '1;
    localparam logic [SpreadW-1:0] SpreadMax = '1;

    localparam logic [CfgIdxW-1:0] RegThreshold = 2'd0;
    localparam logic [CfgIdxW-1:0] RegOnDelay   = 2'd1;
    localparam logic [CfgIdxW-1:0] RegOffDelay  = 2'd2;

    typedef enum logic [2:0] {
        t_IDLE,
        t_SDIV,
        t_VUPD,
        t_VMUL,
        t_VDIV,
        t_TIME,
        t_OUT
    } t_state;

    // Control from the sequencer to the serial divider.
    typedef struct packed {
        logic start;
        logic wide;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

FILE: src/vad_div.sv
// Restoring divider, one quotient bit per cycle, shared by both variance stages.
module vad_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  vad_pkg::t_div_ctl          i_ctl,
    input  logic [vad_pkg::NumW2-1:0]  i_num,
    input  logic [vad_pkg::DivW2-1:0]  i_den,
    output vad_pkg::t_div_sts          o_sts,
    output logic [vad_pkg::NumW2-1:0]  o_quo
);
    import vad_pkg::*;

    logic [NumW2-1:0] r_shift, n_shift;
    logic [DivW2:0]   r_rem, n_rem;
    logic [6:0]       r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [DivW2:0]   w_trial;

    // Shift in one numerator bit, subtract the divisor if it fits.
    always_comb begin
        n_shift = r_shift;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        w_trial = {r_rem[DivW2-1:0], r_shift[NumW2-1]};
        if (i_ctl.start) begin
            n_shift = i_num;
            n_rem   = '0;
            n_cnt   = i_ctl.wide ? 7'(NumW2) : 7'(NumW1);
            if (!i_ctl.wide) n_shift = {i_num[NumW1-1:0], (NumW2-NumW1)'(0)};
            n_busy  = 1'b1;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, i_den}) begin
                n_rem   = w_trial - {1'b0, i_den};
                n_shift = {r_shift[NumW2-2:0], 1'b1};
            end else begin
                n_rem   = w_trial;
                n_shift = {r_shift[NumW2-2:0], 1'b0};
            end
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_shift <= n_shift;
        r_rem   <= n_rem;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    // Narrow mode leaves the quotient in the low bits as well.
    assign o_quo = r_shift;
endmodule

FILE: src/variance_activity_detector.sv
// Variance activity detector.
// Input channel (s_axis): one beat per converter sample, tdata holds the
// 10-bit sample in bits [9:0] and the 32-bit millisecond timestamp in [41:10].
// Output channel (m_axis): one beat per input beat carrying the active flag,
// the sticky stats-ready flag, the latest Q8 window variance and the latest
// Q16 variance spread.
// Configuration: write i_cfg_we with i_cfg_index 0 (threshold), 1 (on delay)
// or 2 (off delay); other indexes are ignored. Write only while idle.
// From the accepting edge to m_axis_tvalid a sample passes the sample-variance
// divide, the variance update once the sample window is full, and the spread
// divide once both windows are full. Both quotients come from one restoring
// divider producing one bit per cycle (40 bits for the sample variance, 72 for
// the spread). One sample is in flight at a time; the next beat is taken once
// the result has moved into the output register, even while that result waits.
// Reset clears both windows, sums, flags and timers and restores the
// register defaults. A stalled receiver holds the output beat; the block
// finishes at most one further sample and then waits with s_axis_tready low.
module variance_activity_detector (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // sample[9:0], time_ms[41:10], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,   // active, stats_ready, window_variance,
                                        // variance_spread, zero pad
    input  logic        i_cfg_we,
    input  logic [vad_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [vad_pkg::CfgW-1:0]    i_cfg_data
);
    import vad_pkg::*;

    // Configuration registers.
    logic [SpreadW-1:0] r_thresh;
    logic [TimeW-1:0]   r_on_dly, r_off_dly;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh  <= SpreadW'(327680);
            r_on_dly  <= TimeW'(1000);
            r_off_dly <= TimeW'(600000);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                RegThreshold: r_thresh  <= i_cfg_data;
                RegOnDelay:   r_on_dly  <= i_cfg_data[TimeW-1:0];
                RegOffDelay:  r_off_dly <= i_cfg_data[TimeW-1:0];
                default: ;
            endcase
        end
    end

    // Window rings, small enough for flip-flops; each is read at its head only.
    logic [SampleBits-1:0] r_sring [SampleWindow];
    logic [VarW-1:0]       r_vring [VarianceWindow];
    logic [IdxW-1:0]       r_shead, r_sfill, r_vhead, r_vfill;
    logic [14:0]           r_ssum;
    logic [24:0]           r_ssq;
    logic [31:0]           r_vsum;
    logic [58:0]           r_vsq;
    logic [VarW-1:0]       r_lvar;
    logic [SpreadW-1:0]    r_lspr;
    logic r_ready, r_active, r_on_arm, r_off_arm;
    logic [TimeW-1:0] r_on_t, r_off_t;

    t_state r_state, n_state;
    logic [TimeW-1:0]      r_now;
    logic [NumW2-1:0]      r_num;
    logic [DivW2-1:0]      r_den;
    logic                  r_wide;
    logic [VarW-1:0]       r_v;
    logic [1:0]            r_step;
    logic [63:0]           r_pa;
    logic                  r_sload;
    logic                  r_go;

    t_div_ctl         w_ctl;
    t_div_sts         w_sts;
    logic [NumW2-1:0] w_quo;

    logic        r_ovalid;
    logic [87:0] r_odata;

    vad_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl), .i_num(r_num),
        .i_den(r_den), .o_sts(w_sts), .o_quo(w_quo)
    );

    assign s_axis_tready = (r_state == t_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    logic w_in_acc;
    assign w_in_acc = s_axis_tvalid && s_axis_tready;

    logic [SampleBits-1:0] w_sold;
    logic [VarW-1:0]       w_vold;
    assign w_sold = r_sring[r_shead];
    assign w_vold = r_vring[r_vhead];

    // Spread test and elapsed-time compares.
    logic w_det, w_on_el, w_off_el;
    logic [TimeW-1:0] w_on_d, w_off_d;
    assign w_det    = r_ready && (r_lspr > r_thresh);
    assign w_on_d   = r_now - r_on_t;
    assign w_off_d  = r_now - r_off_t;
    assign w_on_el  = w_on_d > r_on_dly;
    assign w_off_el = w_off_d > r_off_dly;

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            t_IDLE: if (w_in_acc) n_state = t_SDIV;
            t_SDIV: if (w_sts.done) begin
                n_state = (r_sfill == IdxW'(SampleWindow)) ? t_VUPD : t_TIME;
            end
            t_VUPD: n_state = t_VMUL;
            t_VMUL: if (r_step == 2'd3) begin
                n_state = (r_vfill == IdxW'(VarianceWindow)) ? t_VDIV : t_TIME;
            end
            t_VDIV: if (w_sts.done) n_state = t_TIME;
            t_TIME: n_state = t_OUT;
            t_OUT:  if (!r_ovalid || m_axis_tready) n_state = t_IDLE;
            default: n_state = t_IDLE;
        endcase
    end

    // Window sums updated on accept; the sample window is then divided.
    logic [IdxW-1:0] w_sfill_n;
    logic [14:0]     w_ssum_n;
    logic [24:0]     w_ssq_n;
    logic [SampleBits-1:0] w_x;
    assign w_x = s_axis_tdata[SampleBits-1:0];

    always_comb begin
        w_sfill_n = r_sfill;
        w_ssum_n  = r_ssum;
        w_ssq_n   = r_ssq;
        if (r_sfill == IdxW'(SampleWindow)) begin
            w_ssum_n = w_ssum_n - 15'(w_sold);
            w_ssq_n  = w_ssq_n - 25'(w_sold) * 25'(w_sold);
        end else begin
            w_sfill_n = r_sfill + 5'd1;
        end
        w_ssum_n = w_ssum_n + 15'(w_x);
        w_ssq_n  = w_ssq_n + 25'(w_x) * 25'(w_x);
    end

    // Variance spread numerator pieces, one partial product per cycle.
    logic [31:0] w_vsum_n;
    logic [58:0] w_vsq_n;
    logic [IdxW-1:0] w_vfill_n;
    always_comb begin
        w_vfill_n = r_vfill;
        w_vsum_n  = r_vsum;
        w_vsq_n   = r_vsq;
        if (r_vfill == IdxW'(VarianceWindow)) begin
            w_vsum_n = w_vsum_n - 32'(w_vold);
            w_vsq_n  = w_vsq_n - 59'(r_pa);
        end else begin
            w_vfill_n = r_vfill + 5'd1;
        end
    end

    logic [VarW-1:0] w_vsat;
    assign w_vsat = (w_quo[NumW1-1:VarW] != '0) ? VarMax : w_quo[VarW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= t_IDLE;
            r_shead   <= '0;
            r_sfill   <= '0;
            r_vhead   <= '0;
            r_vfill   <= '0;
            r_ssum    <= '0;
            r_ssq     <= '0;
            r_vsum    <= '0;
            r_vsq     <= '0;
            r_lvar    <= '0;
            r_lspr    <= '0;
            r_ready   <= 1'b0;
            r_active  <= 1'b0;
            r_on_arm  <= 1'b0;
            r_off_arm <= 1'b0;
            r_on_t    <= '0;
            r_off_t   <= '0;
            r_ovalid  <= 1'b0;
            r_wide    <= 1'b0;
            r_step    <= '0;
            for (int i = 0; i < SampleWindow; i++) r_sring[i] <= '0;
            for (int i = 0; i < VarianceWindow; i++) r_vring[i] <= '0;
        end else begin
            r_state <= n_state;
            if (r_ovalid && m_axis_tready && r_state != t_OUT) r_ovalid <= 1'b0;
            case (r_state)
                t_IDLE: if (w_in_acc) begin
                    r_now <= s_axis_tdata[SampleBits+TimeW-1:SampleBits];
                    r_sring[r_shead] <= w_x;
                    r_shead <= (r_shead == IdxW'(SampleWindow-1)) ? '0 : r_shead + 5'd1;
                    r_sfill <= w_sfill_n;
                    r_ssum  <= w_ssum_n;
                    r_ssq   <= w_ssq_n;
                    r_wide  <= 1'b0;
                    r_den   <= SampleDen;
                end
                t_SDIV: begin
                    // The sample numerator is formed from the updated sums.
                    if (r_sload) begin
                        r_num <= NumW2'({(32'(r_ssq) * 32'(SampleWindow)
                                 - 32'(r_ssum) * 32'(r_ssum)), 8'd0});
                    end
                    if (w_sts.done && r_sfill == IdxW'(SampleWindow)) begin
                        r_lvar <= w_vsat;
                        r_v    <= w_vsat;
                    end
                end
                t_VUPD: begin
                    r_pa   <= 64'(w_vold) * 64'(w_vold);
                    r_step <= 2'd0;
                end
                t_VMUL: begin
                    r_step <= r_step + 2'd1;
                    case (r_step)
                        2'd0: begin
                            r_vring[r_vhead] <= r_v;
                            r_vhead <= (r_vhead == IdxW'(VarianceWindow-1)) ? '0
                                       : r_vhead + 5'd1;
                            r_vfill <= w_vfill_n;
                            r_vsum  <= w_vsum_n + 32'(r_v);
                            r_vsq   <= w_vsq_n;
                            r_pa    <= 64'(r_v) * 64'(r_v);
                        end
                        2'd1: begin
                            r_vsq <= r_vsq + 59'(r_pa);
                            r_pa  <= 64'(r_vsum) * 64'(r_vsum);
                        end
                        2'd2: begin
                            r_num <= NumW2'(r_vsq) * NumW2'(VarianceWindow);
                        end
                        default: begin
                            if (NumW2'(r_num) < NumW2'(r_pa)) r_num <= '0;
                            else r_num <= r_num - NumW2'(r_pa);
                            r_den  <= VarianceDen;
                            r_wide <= 1'b1;
                        end
                    endcase
                end
                t_VDIV: if (w_sts.done) begin
                    r_lspr  <= (w_quo[NumW2-1:SpreadW] != '0) ? SpreadMax
                               : w_quo[SpreadW-1:0];
                    r_ready <= 1'b1;
                end
                t_TIME: begin
                    if (w_det) begin
                        r_off_arm <= 1'b0;
                        if (!r_active) begin
                            if (!r_on_arm) begin
                                r_on_arm <= 1'b1;
                                r_on_t   <= r_now;
                            end else if (w_on_el) r_active <= 1'b1;
                        end
                    end else begin
                        r_on_arm <= 1'b0;
                        if (r_active) begin
                            if (!r_off_arm) begin
                                r_off_arm <= 1'b1;
                                r_off_t   <= r_now;
                            end else if (w_off_el) r_active <= 1'b0;
                        end
                    end
                end
                t_OUT: if (!r_ovalid || m_axis_tready) begin
                    r_ovalid <= 1'b1;
                    r_odata  <= {7'd0, r_lspr, r_lvar, r_ready, r_active};
                end
                default: ;
            endcase
        end
    end

    // Divider launches on the cycle after the operands are loaded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sload <= 1'b0;
            r_go    <= 1'b0;
        end else begin
            r_sload <= w_in_acc;
            r_go    <= r_sload
                    || (r_state == t_VMUL && r_step == 2'd3
                        && r_vfill == IdxW'(VarianceWindow));
        end
    end

    always_comb begin
        w_ctl.start = r_go;
        w_ctl.wide  = r_wide;
    end
endmodule

FILE: src/vad_checker.sv
// Port-level checks for the activity detector.
module vad_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [87:0] m_axis_tdata
);
    // A stalled output beat holds its data.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

    // Stats-ready never falls once set.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(m_axis_tdata[1]) && $past(m_axis_tvalid) && m_axis_tvalid
        |-> m_axis_tdata[1])
        else $error("stats_ready fell");

    // An input beat is never taken on two consecutive edges.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken back to back");

    // The padding above the spread stays zero.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[87:81] == 7'd0)
        else $error("pad bits set");
endmodule

bind variance_activity_detector vad_checker u_vad_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
